### hdl/cmk_pkg.sv
// Shared types and constants for the confusion matrix kappa block.
package cmk_pkg;

	localparam int CFG_W   = 5;
	localparam int CLS_W   = 4;
	localparam int FIELD_W = 24;
	localparam int Q_W     = 17;
	localparam int K_W     = 18;
	localparam int STEPS   = 17;

	localparam logic [CFG_W-1:0] NC_RESET = 5'd16;
	localparam logic [Q_W-1:0]   Q_ONE    = 17'h10000;

	typedef enum logic [1:0] {
		DIV_USERS = 2'd0,
		DIV_PROD  = 2'd1,
		DIV_OVER  = 2'd2,
		DIV_KAPPA = 2'd3
	} div_sel_t;

	typedef enum logic [1:0] {
		MUL_ROWCOL = 2'd0,
		MUL_ND     = 2'd1,
		MUL_NN     = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     clr_mem;
		logic     clr_store;
		logic     acc_pair;
		logic     inc_wr;
		logic     rpt_init;
		logic     rd_row;
		logic     rd_col;
		logic     step_j;
		logic     mul;
		mul_sel_t mul_sel;
		logic     save_nd;
		logic     acc_sd;
		logic     den_calc;
		logic     div_start;
		div_sel_t div_sel;
		logic     emit_class;
		logic     emit_sum;
		logic     next_class;
	} cmk_cmd_t;

	typedef struct packed {
		logic pair_ok;
		logic clr_last;
		logic j_last;
		logic i_last;
		logic div_done;
		logic out_free;
	} cmk_sts_t;

endpackage

### hdl/cmk_if.sv
// Handshake interfaces for pair items, result items and the configuration write.
interface cmk_pair_if import cmk_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CLS_W-1:0] inferred_class;
	logic [CLS_W-1:0] observed_class;
	logic             last_pair;
	modport source (output valid, inferred_class, observed_class, last_pair, input ready);
	modport sink   (input valid, inferred_class, observed_class, last_pair, output ready);
endinterface

interface cmk_res_if import cmk_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CLS_W-1:0]        class_index;
	logic [FIELD_W-1:0]      correct_count;
	logic [FIELD_W-1:0]      row_total;
	logic [FIELD_W-1:0]      col_total;
	logic [Q_W-1:0]          users_accuracy;
	logic [Q_W-1:0]          producers_accuracy;
	logic [Q_W-1:0]          overall_accuracy;
	logic signed [K_W-1:0]   kappa;
	logic                    kappa_undefined;
	logic                    input_error;
	logic                    is_summary;
	logic                    last_result;
	modport source (output valid, class_index, correct_count, row_total, col_total,
		users_accuracy, producers_accuracy, overall_accuracy, kappa, kappa_undefined,
		input_error, is_summary, last_result, input ready);
	modport sink (input valid, class_index, correct_count, row_total, col_total,
		users_accuracy, producers_accuracy, overall_accuracy, kappa, kappa_undefined,
		input_error, is_summary, last_result, output ready);
endinterface

interface cmk_cfg_if import cmk_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] num_classes;
	modport source (output valid, num_classes, input ready);
	modport sink   (input valid, num_classes, output ready);
endinterface

### hdl/cmk_div.sv
// Serial Q1.16 ratio unit, one quotient bit per cycle, rounded to nearest.
module cmk_div import cmk_pkg::*; #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [Q_W-1:0] quo
);

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [Q_W-1:0] q_q;
	logic          ge_q;
	logic [DW:0]   dbl;
	logic          bit_ok;

	assign dbl    = {rem_q, 1'b0};
	assign bit_ok = (dbl >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			ge_q  <= (num >= den);
			q_q   <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[Q_W-2:0], bit_ok};
			if (bit_ok)
				rem_q <= DW'(dbl - {1'b0, den_q});
			else
				rem_q <= DW'(dbl);
		end
	end

	assign done = done_q;
	assign quo  = ge_q ? Q_ONE : ({1'b0, q_q[Q_W-1:1]} + {{(Q_W-1){1'b0}}, q_q[0]});

endmodule

### hdl/cmk_ctrl.sv
// Sequencer for pair counting, the report walk and the clearing sweep.
module cmk_ctrl import cmk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pair_valid,
	input  logic     pair_last,
	output logic     pair_ready,
	input  cmk_sts_t sts,
	output cmk_cmd_t cmd
);

	typedef enum logic [20:0] {
		S_CLEAR  = 21'd1 << 0,
		S_IDLE   = 21'd1 << 1,
		S_INC    = 21'd1 << 2,
		S_RINIT  = 21'd1 << 3,
		S_ROW    = 21'd1 << 4,
		S_COL    = 21'd1 << 5,
		S_DRAIN  = 21'd1 << 6,
		S_MUL    = 21'd1 << 7,
		S_SACC   = 21'd1 << 8,
		S_DIVU   = 21'd1 << 9,
		S_STARTP = 21'd1 << 10,
		S_DIVP   = 21'd1 << 11,
		S_EMIT   = 21'd1 << 12,
		S_SMUL1  = 21'd1 << 13,
		S_SMUL2  = 21'd1 << 14,
		S_SDEN   = 21'd1 << 15,
		S_STARTO = 21'd1 << 16,
		S_DIVO   = 21'd1 << 17,
		S_STARTK = 21'd1 << 18,
		S_DIVK   = 21'd1 << 19,
		S_SEMIT  = 21'd1 << 20
	} state_t;

	state_t state_q, state_d;
	logic   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && pair_valid)
				last_q <= pair_last;
		end
	end

	assign pair_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_mem = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (pair_valid) begin
					cmd.acc_pair = 1'b1;
					if (sts.pair_ok)
						state_d = S_INC;
					else if (pair_last)
						state_d = S_RINIT;
				end
			end
			S_INC: begin
				cmd.inc_wr = 1'b1;
				state_d = last_q ? S_RINIT : S_IDLE;
			end
			S_RINIT: begin
				cmd.rpt_init = 1'b1;
				state_d = S_ROW;
			end
			S_ROW: begin
				cmd.rd_row = 1'b1;
				cmd.step_j = 1'b1;
				if (sts.j_last)
					state_d = S_COL;
			end
			S_COL: begin
				cmd.rd_col = 1'b1;
				cmd.step_j = 1'b1;
				if (sts.j_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_MUL;
			S_MUL: begin
				cmd.mul     = 1'b1;
				cmd.mul_sel = MUL_ROWCOL;
				state_d = S_SACC;
			end
			S_SACC: begin
				cmd.acc_sd    = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_USERS;
				state_d = S_DIVU;
			end
			S_DIVU: if (sts.div_done) state_d = S_STARTP;
			S_STARTP: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_PROD;
				state_d = S_DIVP;
			end
			S_DIVP: if (sts.div_done) state_d = S_EMIT;
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_class = 1'b1;
					if (sts.i_last) begin
						state_d = S_SMUL1;
					end else begin
						cmd.next_class = 1'b1;
						state_d = S_ROW;
					end
				end
			end
			S_SMUL1: begin
				cmd.mul     = 1'b1;
				cmd.mul_sel = MUL_ND;
				state_d = S_SMUL2;
			end
			S_SMUL2: begin
				cmd.mul     = 1'b1;
				cmd.mul_sel = MUL_NN;
				cmd.save_nd = 1'b1;
				state_d = S_SDEN;
			end
			S_SDEN: begin
				cmd.den_calc = 1'b1;
				state_d = S_STARTO;
			end
			S_STARTO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_OVER;
				state_d = S_DIVO;
			end
			S_DIVO: if (sts.div_done) state_d = S_STARTK;
			S_STARTK: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_KAPPA;
				state_d = S_DIVK;
			end
			S_DIVK: if (sts.div_done) state_d = S_SEMIT;
			S_SEMIT: begin
				if (sts.out_free) begin
					cmd.emit_sum  = 1'b1;
					cmd.clr_store = 1'b1;
					state_d = S_CLEAR;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

### hdl/cmk_dp.sv
// Count memory, totals, shared multiplier and divider, and the result register.
module cmk_dp import cmk_pkg::*; #(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_BITS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmk_cmd_t              cmd,
	output cmk_sts_t              sts,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [CLS_W-1:0]      inferred_class,
	input  logic [CLS_W-1:0]      observed_class,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [CLS_W-1:0]      class_index,
	output logic [FIELD_W-1:0]    correct_count,
	output logic [FIELD_W-1:0]    row_total,
	output logic [FIELD_W-1:0]    col_total,
	output logic [Q_W-1:0]        users_accuracy,
	output logic [Q_W-1:0]        producers_accuracy,
	output logic [Q_W-1:0]        overall_accuracy,
	output logic signed [K_W-1:0] kappa,
	output logic                  kappa_undefined,
	output logic                  input_error,
	output logic                  is_summary,
	output logic                  last_result
);

	localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_CLASSES);
	localparam int NCW   = $clog2(MAX_CLASSES + 1);
	localparam int CB    = COUNT_BITS;
	localparam int DW    = 2 * COUNT_BITS;

	function automatic logic [FIELD_W-1:0] to_field(input logic [CB-1:0] v);
		logic [CB+FIELD_W-1:0] w;
		w = {{FIELD_W{1'b0}}, v};
		return w[FIELD_W-1:0];
	endfunction

	logic [CB-1:0]    count_mem_q [DEPTH];
	logic [CB-1:0]    rd_data_s1;
	logic [AW-1:0]    rd_addr, wr_addr, pair_addr, pair_addr_q, clr_addr_q;
	logic             wr_en;
	logic [CB-1:0]    wr_data;

	logic [CFG_W-1:0] num_classes_q;
	logic [NCW-1:0]   nc;
	logic [CB-1:0]    pc_q;
	logic             err_q;
	logic [IW-1:0]    i_q, j_q;
	logic             acc_row_s1, acc_col_s1, diag_s1;
	logic [CB-1:0]    row_q, col_q, diag_q, d_q;
	logic [DW-1:0]    s_q, prod_q, nd_q, den_q, kn_q;
	logic             kneg_q;
	logic [CB-1:0]    mul_a, mul_b;
	div_sel_t         dsel_q;
	logic [DW-1:0]    div_num, div_den;
	logic             div_done;
	logic [Q_W-1:0]   div_quo;
	logic [Q_W-1:0]   ua_q, pa_q, oa_q;
	logic [K_W-1:0]   ka_q;
	logic             undef_q;
	logic             out_valid_q;

	always_comb begin
		if (num_classes_q == '0)
			nc = NCW'(1);
		else if (32'(num_classes_q) > 32'(MAX_CLASSES))
			nc = NCW'(MAX_CLASSES);
		else
			nc = NCW'(num_classes_q);
	end

	assign pair_addr = AW'(32'(inferred_class) * 32'(MAX_CLASSES) + 32'(observed_class));

	always_comb begin
		if (cmd.rd_row)
			rd_addr = AW'(32'(i_q) * 32'(MAX_CLASSES) + 32'(j_q));
		else if (cmd.rd_col)
			rd_addr = AW'(32'(j_q) * 32'(MAX_CLASSES) + 32'(i_q));
		else
			rd_addr = pair_addr;
	end

	assign wr_en   = cmd.clr_mem | cmd.inc_wr;
	assign wr_addr = cmd.clr_mem ? clr_addr_q : pair_addr_q;
	assign wr_data = cmd.clr_mem ? '0 : rd_data_s1 + CB'(1);

	always_ff @(posedge clk) begin
		if (wr_en)
			count_mem_q[wr_addr] <= wr_data;
		rd_data_s1 <= count_mem_q[rd_addr];
	end

	assign sts.pair_ok  = (32'(inferred_class) < 32'(nc)) && (32'(observed_class) < 32'(nc))
		&& (pc_q != {CB{1'b1}});
	assign sts.clr_last = (clr_addr_q == AW'(DEPTH - 1));
	assign sts.j_last   = (32'(j_q) + 32'd1 == 32'(nc));
	assign sts.i_last   = (32'(i_q) + 32'd1 == 32'(nc));
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NC_RESET;
			pc_q          <= '0;
			err_q         <= 1'b0;
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
			acc_row_s1    <= 1'b0;
			acc_col_s1    <= 1'b0;
		end else begin
			if (cfg_we)
				num_classes_q <= cfg_data;
			if (cmd.clr_store) begin
				pc_q  <= '0;
				err_q <= 1'b0;
			end else if (cmd.acc_pair) begin
				if (sts.pair_ok)
					pc_q <= pc_q + CB'(1);
				else
					err_q <= 1'b1;
			end
			if (cmd.clr_store)
				clr_addr_q <= '0;
			else if (cmd.clr_mem && !sts.clr_last)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.emit_class || cmd.emit_sum)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			acc_row_s1 <= cmd.rd_row;
			acc_col_s1 <= cmd.rd_col;
		end
	end

	always_comb begin
		mul_a = pc_q;
		mul_b = pc_q;
		case (cmd.mul_sel)
			MUL_ROWCOL: begin
				mul_a = row_q;
				mul_b = col_q;
			end
			MUL_ND: mul_b = d_q;
			default: mul_b = pc_q;
		endcase
	end

	always_comb begin
		div_num = {{CB{1'b0}}, d_q};
		div_den = {{CB{1'b0}}, pc_q};
		case (cmd.div_sel)
			DIV_USERS: begin
				div_num = {{CB{1'b0}}, diag_q};
				div_den = {{CB{1'b0}}, row_q};
			end
			DIV_PROD: begin
				div_num = {{CB{1'b0}}, diag_q};
				div_den = {{CB{1'b0}}, col_q};
			end
			DIV_KAPPA: begin
				div_num = kn_q;
				div_den = den_q;
			end
			default: ;
		endcase
	end

	cmk_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.acc_pair)
			pair_addr_q <= pair_addr;
		if (cmd.rd_row)
			diag_s1 <= (j_q == i_q);
		if (cmd.rpt_init) begin
			i_q <= '0;
			j_q <= '0;
			d_q <= '0;
			s_q <= '0;
		end else if (cmd.next_class) begin
			i_q <= i_q + IW'(1);
		end
		if (cmd.step_j)
			j_q <= sts.j_last ? '0 : j_q + IW'(1);
		if (cmd.rpt_init || cmd.next_class) begin
			row_q  <= '0;
			col_q  <= '0;
			diag_q <= '0;
		end else begin
			if (acc_row_s1) begin
				row_q <= row_q + rd_data_s1;
				if (diag_s1)
					diag_q <= rd_data_s1;
			end
			if (acc_col_s1)
				col_q <= col_q + rd_data_s1;
		end
		if (cmd.mul)
			prod_q <= DW'(mul_a * mul_b);
		if (cmd.acc_sd) begin
			s_q <= s_q + prod_q;
			d_q <= d_q + diag_q;
		end
		if (cmd.save_nd)
			nd_q <= prod_q;
		if (cmd.den_calc) begin
			den_q  <= prod_q - s_q;
			kneg_q <= (nd_q < s_q);
			kn_q   <= (nd_q >= s_q) ? nd_q - s_q : s_q - nd_q;
		end
		if (cmd.div_start)
			dsel_q <= cmd.div_sel;
		if (div_done) begin
			case (dsel_q)
				DIV_USERS: ua_q <= (row_q == '0) ? '0 : div_quo;
				DIV_PROD:  pa_q <= (col_q == '0) ? '0 : div_quo;
				DIV_OVER:  oa_q <= (pc_q == '0) ? '0 : div_quo;
				default: begin
					undef_q <= (den_q == '0);
					if (den_q == '0)
						ka_q <= '0;
					else if (kneg_q)
						ka_q <= K_W'(0) - K_W'(div_quo);
					else
						ka_q <= K_W'(div_quo);
				end
			endcase
		end
		if (cmd.emit_class) begin
			class_index        <= CLS_W'(i_q);
			correct_count      <= to_field(diag_q);
			row_total          <= to_field(row_q);
			col_total          <= to_field(col_q);
			users_accuracy     <= ua_q;
			producers_accuracy <= pa_q;
			overall_accuracy   <= '0;
			kappa              <= '0;
			kappa_undefined    <= 1'b0;
			input_error        <= err_q;
			is_summary         <= 1'b0;
			last_result        <= 1'b0;
		end else if (cmd.emit_sum) begin
			class_index        <= '0;
			correct_count      <= to_field(d_q);
			row_total          <= to_field(pc_q);
			col_total          <= to_field(pc_q);
			users_accuracy     <= '0;
			producers_accuracy <= '0;
			overall_accuracy   <= oa_q;
			kappa              <= ka_q;
			kappa_undefined    <= undef_q;
			input_error        <= err_q;
			is_summary         <= 1'b1;
			last_result        <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/confusion_matrix_kappa.sv
// Confusion matrix counter with per-class accuracies and Cohen's kappa report.
// A counted pair item is a read, then a write back of one count cell; a dropped
// pair is not written. A pair with last_pair set starts the report after a setup
// state: for each of C classes in use the block reads row and column of the count
// memory, then runs two serial divisions of 17 steps each and emits a class item
// once the result side is free; the summary item follows the last class.
// After the report, and after reset, a clearing sweep writes zero to all
// MAX_CLASSES*MAX_CLASSES cells, one per cycle, during which no pair is taken.
// Configuration is always accepted.
module confusion_matrix_kappa import cmk_pkg::*; #(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_BITS  = 24
) (
	input logic      clk,
	input logic      arst_n,
	cmk_pair_if.sink pair,
	cmk_res_if.source result,
	cmk_cfg_if.sink  cfg
);

	cmk_cmd_t cmd;
	cmk_sts_t sts;

	assign cfg.ready = 1'b1;

	cmk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair.valid),
		.pair_last  (pair.last_pair),
		.pair_ready (pair.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	cmk_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg.valid),
		.cfg_data           (cfg.num_classes),
		.inferred_class     (pair.inferred_class),
		.observed_class     (pair.observed_class),
		.out_ready          (result.ready),
		.out_valid          (result.valid),
		.class_index        (result.class_index),
		.correct_count      (result.correct_count),
		.row_total          (result.row_total),
		.col_total          (result.col_total),
		.users_accuracy     (result.users_accuracy),
		.producers_accuracy (result.producers_accuracy),
		.overall_accuracy   (result.overall_accuracy),
		.kappa              (result.kappa),
		.kappa_undefined    (result.kappa_undefined),
		.input_error        (result.input_error),
		.is_summary         (result.is_summary),
		.last_result        (result.last_result)
	);

endmodule

### hdl/cmk_checker.sv
// Port-level checks for the confusion matrix kappa block, bound to the top level.
module cmk_checker import cmk_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pair_valid,
	input logic                  pair_ready,
	input logic                  pair_last,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [FIELD_W-1:0]    correct_count,
	input logic [FIELD_W-1:0]    row_total,
	input logic [FIELD_W-1:0]    col_total,
	input logic [Q_W-1:0]        overall_accuracy,
	input logic signed [K_W-1:0] kappa,
	input logic                  kappa_undefined,
	input logic                  is_summary,
	input logic                  last_result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(correct_count) && $stable(is_summary))
		else $error("result item changed while stalled");

	a_report_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready && pair_last |=> !pair_ready)
		else $error("pair taken right after a last pair");

	a_summary_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (is_summary == last_result) && (!is_summary || row_total == col_total))
		else $error("summary item malformed");

	a_class_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_summary |-> kappa == '0 && overall_accuracy == '0 && !kappa_undefined)
		else $error("class item carries summary fields");

endmodule

bind confusion_matrix_kappa cmk_checker u_cmk_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.pair_valid       (pair.valid),
	.pair_ready       (pair.ready),
	.pair_last        (pair.last_pair),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.correct_count    (result.correct_count),
	.row_total        (result.row_total),
	.col_total        (result.col_total),
	.overall_accuracy (result.overall_accuracy),
	.kappa            (result.kappa),
	.kappa_undefined  (result.kappa_undefined),
	.is_summary       (result.is_summary),
	.last_result      (result.last_result)
);

### verif/cmk_tb_if.sv
`timescale 1ns / 100ps
// Scoreboard package: predicted result items and their comparison.
package cmk_tb_pkg;
	import cmk_pkg::*;

	typedef struct {
		logic [CLS_W-1:0]      class_index;
		logic [FIELD_W-1:0]    correct_count;
		logic [FIELD_W-1:0]    row_total;
		logic [FIELD_W-1:0]    col_total;
		logic [Q_W-1:0]        users_accuracy;
		logic [Q_W-1:0]        producers_accuracy;
		logic [Q_W-1:0]        overall_accuracy;
		logic [K_W-1:0]        kappa;
		logic                  kappa_undefined;
		logic                  input_error;
		logic                  is_summary;
		logic                  last_result;
	} report_t;

	class kappa_scoreboard;
		logic [23:0] cells [16][16];
		logic [23:0] pairs;
		bit          dropped;
		logic [4:0]  classes_reg;
		report_t     pending [$];
		int          errors;
		int          reports;

		function new();
			clear();
			classes_reg = NC_RESET;
			errors = 0;
			reports = 0;
		endfunction

		function void clear();
			foreach (cells[i, j]) cells[i][j] = '0;
			pairs = '0;
			dropped = 0;
		endfunction

		function logic [16:0] q16(longint unsigned num, longint unsigned den);
			longint unsigned rem;
			logic [16:0] q;
			q = 0;
			if (num >= den) return Q_ONE;
			rem = num;
			for (int b = 0; b < 17; b++) begin
				if (rem >= den - rem) begin
					rem = rem - (den - rem);
					q = {q[15:0], 1'b1};
				end else begin
					rem = rem * 2;
					q = {q[15:0], 1'b0};
				end
			end
			return (q >> 1) + q[0];
		endfunction

		function void note_pair(logic [3:0] inf, logic [3:0] obs, logic last);
			int nc;
			longint unsigned rows [16], cols [16], n, d, s, nd, den;
			report_t r;
			logic [16:0] mag;
			nc = classes_reg < 1 ? 1 : (classes_reg > 16 ? 16 : classes_reg);
			if (inf >= nc || obs >= nc || pairs == 24'hFFFFFF) dropped = 1;
			else begin
				cells[inf][obs]++;
				pairs++;
			end
			if (!last) return;
			reports++;
			n = pairs; d = 0; s = 0;
			for (int i = 0; i < 16; i++) begin rows[i] = 0; cols[i] = 0; end
			for (int i = 0; i < nc; i++)
				for (int j = 0; j < nc; j++) begin
					rows[i] += cells[i][j];
					cols[j] += cells[i][j];
				end
			for (int i = 0; i < nc; i++) begin
				r = '{default: '0};
				d += cells[i][i];
				s += rows[i] * cols[i];
				r.class_index = 4'(i);
				r.correct_count = cells[i][i];
				r.row_total = 24'(rows[i]);
				r.col_total = 24'(cols[i]);
				r.users_accuracy = rows[i] ? q16(cells[i][i], rows[i]) : '0;
				r.producers_accuracy = cols[i] ? q16(cells[i][i], cols[i]) : '0;
				r.input_error = dropped;
				pending.push_back(r);
			end
			r = '{default: '0};
			nd = n * d;
			den = n * n - s;
			if (den == 0) r.kappa_undefined = 1;
			else if (nd >= s) r.kappa = {1'b0, q16(nd - s, den)};
			else begin
				mag = q16(s - nd, den);
				r.kappa = -{1'b0, mag};
			end
			r.correct_count = 24'(d);
			r.row_total = 24'(n);
			r.col_total = 24'(n);
			r.overall_accuracy = n ? q16(d, n) : '0;
			r.input_error = dropped;
			r.is_summary = 1;
			r.last_result = 1;
			pending.push_back(r);
			clear();
		endfunction

		function void check_result(report_t a);
			report_t e;
			if (pending.size() == 0) begin
				$error("unexpected result item, class_index %0d", a.class_index);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.class_index !== e.class_index) bad("class_index", e.class_index, a.class_index);
			if (a.correct_count !== e.correct_count)
				bad("correct_count", e.correct_count, a.correct_count);
			if (a.row_total !== e.row_total) bad("row_total", e.row_total, a.row_total);
			if (a.col_total !== e.col_total) bad("col_total", e.col_total, a.col_total);
			if (a.users_accuracy !== e.users_accuracy)
				bad("users_accuracy", e.users_accuracy, a.users_accuracy);
			if (a.producers_accuracy !== e.producers_accuracy)
				bad("producers_accuracy", e.producers_accuracy, a.producers_accuracy);
			if (a.overall_accuracy !== e.overall_accuracy)
				bad("overall_accuracy", e.overall_accuracy, a.overall_accuracy);
			if (a.kappa !== e.kappa) bad("kappa", e.kappa, a.kappa);
			if (a.kappa_undefined !== e.kappa_undefined)
				bad("kappa_undefined", e.kappa_undefined, a.kappa_undefined);
			if (a.input_error !== e.input_error) bad("input_error", e.input_error, a.input_error);
			if (a.is_summary !== e.is_summary) bad("is_summary", e.is_summary, a.is_summary);
			if (a.last_result !== e.last_result) bad("last_result", e.last_result, a.last_result);
		endfunction

		function void bad(string f, logic [31:0] e, logic [31:0] a);
			$error("%s: expected 0x%0h, got 0x%0h", f, e, a);
			errors++;
		endfunction
	endclass
endpackage

### verif/confusion_matrix_kappa_test.sv
`timescale 1ns / 100ps
// Random and directed test of the confusion matrix kappa block against its own predictor.
module confusion_matrix_kappa_test;
	import cmk_pkg::*;
	import cmk_tb_pkg::*;

	logic clk;
	logic arst_n;
	bit   calm;
	int   stall_cnt;
	int   pairs_sent;
	int   results_seen;
	bit   timed_out;

	cmk_pair_if pair_ch ();
	cmk_res_if  res_ch ();
	cmk_cfg_if  cfg_ch ();

	kappa_scoreboard board;

	confusion_matrix_kappa i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pair  (pair_ch.sink),
		.result(res_ch.source),
		.cfg   (cfg_ch.sink)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		board = new();
		arst_n = 0;
		pair_ch.valid = 0;
		pair_ch.inferred_class = 0;
		pair_ch.observed_class = 0;
		pair_ch.last_pair = 0;
		cfg_ch.valid = 0;
		cfg_ch.num_classes = 0;
		res_ch.ready = 0;
		calm = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	function bit idle_now();
		return !calm && ($urandom_range(99) < 34);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			res_ch.ready <= !idle_now();
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				board.check_result('{res_ch.class_index, res_ch.correct_count,
					res_ch.row_total, res_ch.col_total, res_ch.users_accuracy,
					res_ch.producers_accuracy, res_ch.overall_accuracy, res_ch.kappa,
					res_ch.kappa_undefined, res_ch.input_error, res_ch.is_summary,
					res_ch.last_result});
			end
		end
	end

	always @(posedge clk) begin
		if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready) || !arst_n)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > 20000 && !timed_out) begin
			timed_out = 1;
			$display("confusion_matrix_kappa: mismatch");
			$finish;
		end
	end

	// valid stays up after an accepted item until the next item or an idle cycle
	task automatic send_pair(logic [3:0] inf, logic [3:0] obs, logic last);
		while (idle_now()) begin
			pair_ch.valid <= 0;
			@(posedge clk);
		end
		pair_ch.valid <= 1;
		pair_ch.inferred_class <= inf;
		pair_ch.observed_class <= obs;
		pair_ch.last_pair <= last;
		do @(posedge clk); while (!pair_ch.ready);
		board.note_pair(inf, obs, last);
		pairs_sent++;
	endtask

	task automatic drain();
		pair_ch.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_classes(logic [4:0] v);
		drain();
		cfg_ch.valid <= 1;
		cfg_ch.num_classes <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		board.classes_reg = v;
	endtask

	task automatic random_set(int len, int nc, int bad_pct);
		logic [3:0] a, b;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < bad_pct) begin
				a = 4'($urandom); b = 4'($urandom);
			end else begin
				a = 4'($urandom_range(nc - 1));
				b = ($urandom_range(1) != 0) ? a : 4'($urandom_range(nc - 1));
			end
			send_pair(a, b, k == len - 1);
		end
	endtask

	initial begin
		logic [4:0] settings [6];
		settings = '{5'd1, 5'd2, 5'd5, 5'd16, 5'd0, 5'd31};
		@(posedge arst_n);
		@(posedge clk);
		// directed: reset setting 16, extremes, full diagonal and out of range
		send_pair(0, 0, 0);
		send_pair(15, 15, 0);
		send_pair(15, 0, 0);
		send_pair(0, 15, 1);
		send_pair(7, 8, 1);
		send_pair(3, 3, 1);
		set_classes(5'd2);
		send_pair(0, 1, 0);
		send_pair(1, 0, 1);
		send_pair(2, 0, 0);
		send_pair(1, 1, 1);
		send_pair(5, 9, 1);
		set_classes(5'd1);
		send_pair(0, 0, 0);
		send_pair(1, 0, 0);
		send_pair(0, 0, 1);
		set_classes(5'd0);
		send_pair(0, 0, 1);
		set_classes(5'd31);
		send_pair(10, 5, 0);
		send_pair(5, 10, 1);
		set_classes(5'd3);
		send_pair(0, 0, 0);
		// change during a set: class 2 counted but not reported
		set_classes(5'd4);
		send_pair(3, 2, 0);
		set_classes(5'd2);
		send_pair(2, 1, 0);
		send_pair(1, 1, 1);
		calm = 1;
		for (int r = 0; r < 3; r++) random_set($urandom_range(2, 8), 16, 5);
		calm = 0;
		for (int p = 0; p < 14; p++) begin
			logic [4:0] v;
			int nc;
			v = settings[p % 6];
			if (p >= 6) v = 5'($urandom);
			set_classes(v);
			nc = v < 1 ? 1 : (v > 16 ? 16 : v);
			random_set($urandom_range(3, 16), nc, 10);
			if (p == 4) drain();
		end
		drain();
		$display("run covered %0d pairs, %0d reports, %0d result items",
			pairs_sent, board.reports, results_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("confusion_matrix_kappa: match");
		else
			$display("confusion_matrix_kappa: mismatch");
		$finish;
	end
endmodule
